[hw/rtl/prtcb_pkg.sv]
// Package for the point rigid-transform and crop-box block.
// Holds widths, register codes, config and pipeline control types, and the output clamp.
// No dependencies.
`default_nettype none

package prtcb_pkg;

    localparam int COORD_W    = 24;
    localparam int COEF_W     = 18;
    localparam int TRANS_W    = 20;
    localparam int FRAC_W     = 16;
    localparam int ROI_W      = 23;
    localparam int ZLIM_W     = 2 * COORD_W;
    localparam int ROW_W      = 3 * COEF_W;
    localparam int TRANS_ALL_W = 3 * TRANS_W;
    localparam int PROD_W     = COORD_W + COEF_W;
    localparam int ACC_W      = PROD_W + 2;
    localparam int SUM_W      = ACC_W - FRAC_W + 1;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 64;
    localparam int TDATA_W    = 3 * COORD_W;
    localparam int N_STAGES   = 4;

    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (FRAC_W - 1);
    localparam logic signed [SUM_W-1:0] SAT_HI     = SUM_W'((1 << (COORD_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0] SAT_LO     = -SUM_W'(1 << (COORD_W - 1));

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROT_X     = 4'd0,
        CFG_ROT_Y     = 4'd1,
        CFG_ROT_Z     = 4'd2,
        CFG_TRANS     = 4'd3,
        CFG_ROI_FRONT = 4'd4,
        CFG_ROI_BACK  = 4'd5,
        CFG_ROI_SIDE  = 4'd6,
        CFG_ROI_Z     = 4'd7
    } cfg_index_t;

    typedef struct packed {
        logic [ROW_W-1:0]       rot_x;
        logic [ROW_W-1:0]       rot_y;
        logic [ROW_W-1:0]       rot_z;
        logic [TRANS_ALL_W-1:0] trans;
        logic [ROI_W-1:0]       front;
        logic [ROI_W-1:0]       back;
        logic [ROI_W-1:0]       side;
        logic [ZLIM_W-1:0]      zlim;
    } cfg_regs_t;

    // load[k]: stage k takes its input this cycle; valid[k]: stage k holds a point
    typedef struct packed {
        logic [N_STAGES-1:0] load;
        logic [N_STAGES-1:0] valid;
    } pipe_ctl_t;

    typedef struct packed {
        logic fin;
        logic last;
    } pt_flags_t;

    function automatic logic [COORD_W-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] c;
        priority if (v > SAT_HI)
            c = SAT_HI;
        else if (v < SAT_LO)
            c = SAT_LO;
        else
            c = v;
        return c[COORD_W-1:0];
    endfunction

endpackage

`default_nettype wire

[hw/rtl/point_rigid_transform_crop_box.sv]
// Point rigid-transform and crop-box filter, top level.
// Instantiates prtcb_cfg, prtcb_ctrl, prtcb_row (three rows) and prtcb_crop; uses prtcb_pkg.
//
// Takes one point per clock while the output does not stall and gives one result per
// point, in order. A point accepted on the input stream passes through four register
// stages to the output: one of 24x18 products, one of the rounded three-term sum, one
// of shift and translation add, and the register holding box test and clamped
// coordinates. Every stage holds its point while the output is stalled and frees as
// soon as the one after it moves, so the sustained rate is one point per cycle. Config
// writes are always ready and are registered in prtcb_cfg; write only while no point is
// in flight.
`default_nettype none

module point_rigid_transform_crop_box
    import prtcb_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [TDATA_W-1:0]    s_axis_tdata,   // in_x, in_y, in_z
    input  wire logic                  s_axis_tuser,   // is_finite
    input  wire logic                  s_axis_tlast,   // in_last
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [TDATA_W-1:0]         m_axis_tdata,   // out_x, out_y, out_z
    output logic                       m_axis_tuser,   // keep
    output logic                       m_axis_tlast,   // out_last
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_regs_t               cfg;
    pipe_ctl_t               ctl;
    pt_flags_t               in_flags;
    pt_flags_t               flags_s3;
    logic signed [COORD_W-1:0] px, py, pz;
    logic signed [SUM_W-1:0] tx, ty, tz;
    logic [COORD_W-1:0]      ox, oy, oz;

    assign px = s_axis_tdata[COORD_W-1:0];
    assign py = s_axis_tdata[2*COORD_W-1:COORD_W];
    assign pz = s_axis_tdata[3*COORD_W-1:2*COORD_W];
    assign in_flags.fin  = s_axis_tuser;
    assign in_flags.last = s_axis_tlast;

    prtcb_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .regs      (cfg)
    );

    prtcb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_flags  (in_flags),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .ctl       (ctl),
        .flags_s3  (flags_s3)
    );

    prtcb_row u_row_x (
        .clk   (clk),
        .ctl   (ctl),
        .px    (px),
        .py    (py),
        .pz    (pz),
        .row   (cfg.rot_x),
        .trans (cfg.trans[TRANS_W-1:0]),
        .coord (tx)
    );

    prtcb_row u_row_y (
        .clk   (clk),
        .ctl   (ctl),
        .px    (px),
        .py    (py),
        .pz    (pz),
        .row   (cfg.rot_y),
        .trans (cfg.trans[2*TRANS_W-1:TRANS_W]),
        .coord (ty)
    );

    prtcb_row u_row_z (
        .clk   (clk),
        .ctl   (ctl),
        .px    (px),
        .py    (py),
        .pz    (pz),
        .row   (cfg.rot_z),
        .trans (cfg.trans[3*TRANS_W-1:2*TRANS_W]),
        .coord (tz)
    );

    prtcb_crop u_crop (
        .clk      (clk),
        .ctl      (ctl),
        .cfg      (cfg),
        .x        (tx),
        .y        (ty),
        .z        (tz),
        .flags    (flags_s3),
        .out_x    (ox),
        .out_y    (oy),
        .out_z    (oz),
        .keep     (m_axis_tuser),
        .out_last (m_axis_tlast)
    );

    assign m_axis_tdata = {oz, oy, ox};

endmodule

`default_nettype wire

[hw/rtl/prtcb_cfg.sv]
// Configuration register file for the transform and crop box.
// Depends on prtcb_pkg.
`default_nettype none

module prtcb_cfg
    import prtcb_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_regs_t                  regs
);

    cfg_regs_t regs_reg;
    cfg_regs_t regs_next;

    assign cfg_ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_ROT_X:     regs_next.rot_x = cfg_data[ROW_W-1:0];
                CFG_ROT_Y:     regs_next.rot_y = cfg_data[ROW_W-1:0];
                CFG_ROT_Z:     regs_next.rot_z = cfg_data[ROW_W-1:0];
                CFG_TRANS:     regs_next.trans = cfg_data[TRANS_ALL_W-1:0];
                CFG_ROI_FRONT: regs_next.front = cfg_data[ROI_W-1:0];
                CFG_ROI_BACK:  regs_next.back  = cfg_data[ROI_W-1:0];
                CFG_ROI_SIDE:  regs_next.side  = cfg_data[ROI_W-1:0];
                CFG_ROI_Z:     regs_next.zlim  = cfg_data[ZLIM_W-1:0];
                default:       regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // identity rotation, no translation, box 4.0 / 0.8 / 2.0, z -0.6 .. 1.8
            regs_reg.rot_x <= ROW_W'(54'd65536);
            regs_reg.rot_y <= ROW_W'(54'd17179869184);
            regs_reg.rot_z <= ROW_W'(54'd4503599627370496);
            regs_reg.trans <= '0;
            regs_reg.front <= ROI_W'(23'd262144);
            regs_reg.back  <= ROI_W'(23'd52429);
            regs_reg.side  <= ROI_W'(23'd131072);
            regs_reg.zlim  <= ZLIM_W'(48'd1979141023334);
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/prtcb_ctrl.sv]
// Pipeline control: valid bits, per-stage load enables and the side-band flags.
// Depends on prtcb_pkg.
`default_nettype none

module prtcb_ctrl
    import prtcb_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire pt_flags_t in_flags,
    output logic           out_valid,
    input  wire logic      out_ready,
    output pipe_ctl_t      ctl,
    output pt_flags_t      flags_s3
);

    logic [N_STAGES-1:0] valid_reg;
    logic [N_STAGES-1:0] valid_next;
    logic [N_STAGES-1:0] load;
    pt_flags_t           flags_reg [N_STAGES-1];

    // a stage loads when empty or when the one after it moves on
    always_comb
    begin
        load[N_STAGES-1] = !valid_reg[N_STAGES-1] || out_ready;
        for (int k = N_STAGES - 2; k >= 0; k--)
            load[k] = !valid_reg[k] || load[k+1];
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (load[0])
            valid_next[0] = in_valid;
        for (int k = 1; k < N_STAGES; k++)
            if (load[k])
                valid_next[k] = valid_reg[k-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
            flags_reg[0] <= in_flags;
        for (int k = 1; k < N_STAGES - 1; k++)
            if (load[k])
                flags_reg[k] <= flags_reg[k-1];
    end

    assign in_ready  = load[0];
    assign out_valid = valid_reg[N_STAGES-1];
    assign ctl.load  = load;
    assign ctl.valid = valid_reg;
    assign flags_s3  = flags_reg[N_STAGES-2];

endmodule

`default_nettype wire

[hw/rtl/prtcb_row.sv]
// One row of the rotation plus translation, three register stages:
// products, rounded sum, shift and translation add. Depends on prtcb_pkg.
`default_nettype none

module prtcb_row
    import prtcb_pkg::*;
(
    input  wire logic                      clk,
    input  wire pipe_ctl_t                 ctl,
    input  wire logic signed [COORD_W-1:0] px,
    input  wire logic signed [COORD_W-1:0] py,
    input  wire logic signed [COORD_W-1:0] pz,
    input  wire logic [ROW_W-1:0]          row,
    input  wire logic [TRANS_W-1:0]        trans,
    output logic signed [SUM_W-1:0]        coord
);

    logic signed [COEF_W-1:0]  c0, c1, c2;
    logic signed [TRANS_W-1:0] t_s;
    logic signed [PROD_W-1:0]  prod_next [3];
    logic signed [PROD_W-1:0]  prod_reg  [3];
    logic signed [ACC_W-1:0]   acc_next;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [SUM_W-1:0]   coord_next;
    logic signed [SUM_W-1:0]   coord_reg;

    assign c0  = row[COEF_W-1:0];
    assign c1  = row[2*COEF_W-1:COEF_W];
    assign c2  = row[3*COEF_W-1:2*COEF_W];
    assign t_s = trans;

    assign prod_next[0] = px * c0;
    assign prod_next[1] = py * c1;
    assign prod_next[2] = pz * c2;

    // round to nearest, ties up: add half an LSB, then floor shift
    assign acc_next = ACC_W'(prod_reg[0]) + ACC_W'(prod_reg[1]) + ACC_W'(prod_reg[2])
                      + ROUND_HALF;

    assign coord_next = SUM_W'(acc_reg >>> FRAC_W) + SUM_W'(t_s);

    always_ff @(posedge clk)
    begin
        if (ctl.load[0])
        begin
            for (int k = 0; k < 3; k++)
                prod_reg[k] <= prod_next[k];
        end
        if (ctl.load[1])
            acc_reg <= acc_next;
        if (ctl.load[2])
            coord_reg <= coord_next;
    end

    assign coord = coord_reg;

endmodule

`default_nettype wire

[hw/rtl/prtcb_crop.sv]
// Box test on the unclamped target-frame point, output clamp and output register.
// Depends on prtcb_pkg.
`default_nettype none

module prtcb_crop
    import prtcb_pkg::*;
(
    input  wire logic                    clk,
    input  wire pipe_ctl_t               ctl,
    input  wire cfg_regs_t               cfg,
    input  wire logic signed [SUM_W-1:0] x,
    input  wire logic signed [SUM_W-1:0] y,
    input  wire logic signed [SUM_W-1:0] z,
    input  wire pt_flags_t               flags,
    output logic [COORD_W-1:0]           out_x,
    output logic [COORD_W-1:0]           out_y,
    output logic [COORD_W-1:0]           out_z,
    output logic                         keep,
    output logic                         out_last
);

    logic signed [SUM_W-1:0] front_s, back_s, side_s, zmin_s, zmax_s;
    logic                    in_box;
    logic [COORD_W-1:0]      x_reg, y_reg, z_reg;
    logic                    keep_reg, last_reg;

    assign front_s = {{(SUM_W-ROI_W){1'b0}}, cfg.front};
    assign back_s  = {{(SUM_W-ROI_W){1'b0}}, cfg.back};
    assign side_s  = {{(SUM_W-ROI_W){1'b0}}, cfg.side};
    assign zmin_s  = SUM_W'(signed'(cfg.zlim[COORD_W-1:0]));
    assign zmax_s  = SUM_W'(signed'(cfg.zlim[ZLIM_W-1:COORD_W]));

    // |y| <= side written as two compares; faces count as inside
    assign in_box = (x >= -back_s) && (x <= front_s) &&
                    (y <= side_s) && (y >= -side_s) &&
                    (z >= zmin_s) && (z <= zmax_s);

    always_ff @(posedge clk)
    begin
        if (ctl.load[N_STAGES-1])
        begin
            x_reg    <= sat_coord(x);
            y_reg    <= sat_coord(y);
            z_reg    <= sat_coord(z);
            keep_reg <= flags.fin && in_box;
            last_reg <= flags.last;
        end
    end

    assign out_x    = x_reg;
    assign out_y    = y_reg;
    assign out_z    = z_reg;
    assign keep     = keep_reg;
    assign out_last = last_reg;

endmodule

`default_nettype wire

[hw/rtl/prtcb_checker.sv]
// Port-level checks for point_rigid_transform_crop_box, attached by bind.
// Depends on prtcb_pkg.
`default_nettype none

module prtcb_checker
    import prtcb_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               s_axis_tvalid,
    input wire logic               s_axis_tready,
    input wire logic               s_axis_tuser,
    input wire logic               s_axis_tlast,
    input wire logic               m_axis_tvalid,
    input wire logic               m_axis_tready,
    input wire logic [TDATA_W-1:0] m_axis_tdata,
    input wire logic               m_axis_tuser,
    input wire logic               m_axis_tlast
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // a result is withdrawn only after it was taken
    a_out_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(m_axis_tvalid) |-> $past(m_axis_tready))
        else $error("result dropped without a request");

    // with the output never stalled, an accepted request shows up on the output with its end mark
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $past(s_axis_tvalid && s_axis_tready && rst_n, 4) && $past(rst_n, 3)
            && $past(rst_n, 2) && $past(rst_n, 1) && $past(m_axis_tready, 3)
            && $past(m_axis_tready, 2) && $past(m_axis_tready, 1)
        |-> m_axis_tvalid && (m_axis_tlast == $past(s_axis_tlast, 4)))
        else $error("result missing or end mark wrong after four cycles");

    // with the output never stalled, a non-finite point is not kept
    a_nonfinite: assert property (@(posedge clk) disable iff (!rst_n)
        $past(s_axis_tvalid && s_axis_tready && !s_axis_tuser && rst_n, 4)
            && $past(rst_n, 3) && $past(rst_n, 2) && $past(rst_n, 1)
            && $past(m_axis_tready, 3) && $past(m_axis_tready, 2)
            && $past(m_axis_tready, 1)
        |-> !m_axis_tuser)
        else $error("non-finite point kept");

endmodule

bind point_rigid_transform_crop_box prtcb_checker u_prtcb_checker (.*);

`default_nettype wire
